FILE: design/ftbp_pkg.sv
// Shared types, constants and state codes of the per-flow token bucket policer.
`default_nettype none
package ftbp_pkg;

  localparam int unsigned FLOW_IDX_W = 10;
  localparam int unsigned FLOW_SLOTS = 1 << FLOW_IDX_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  // Low 32 bits of floor(2^62 / 1e9); the full reciprocal is 2^32 plus this value.
  localparam logic [31:0] RECIP_LO = 32'd316718722;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE  = 1'b0,
    CFG_BURST = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [FLOW_IDX_W-1:0] flow_index;
    logic [63:0]           now_ns;
    logic [31:0]           override_rate;
    logic [31:0]           override_burst;
  } in_word_t;

  typedef struct packed {
    logic        allow;
    logic        limiter_active;
    logic        new_flow;
    logic [31:0] tokens_left;
  } out_word_t;

  // Back-end state machine.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_NEED,
    BK_DIV,
    BK_MUL1,
    BK_MUL2,
    BK_EST,
    BK_FIX1,
    BK_FIX2,
    BK_CAP,
    BK_DONE,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

FILE: design/ftbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ftbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: design/ftbp_div.sv
// Restoring 64-by-64 bit divider, one quotient bit per cycle.
`default_nettype none
module ftbp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[63]} - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // The remainder can exceed 64 bits by one before the subtract; the 65-bit trial covers it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = busy_r && (cnt_r == 7'd1);
  assign quotient = trial[64] ? {quo_r[62:0], 1'b0} : {quo_r[62:0], 1'b1};
endmodule
`default_nettype wire

FILE: design/ftbp_front.sv
// Front end: accepts packets, resolves the limit and queues classified words.
`default_nettype none
module ftbp_front
  import ftbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  input  wire in_word_t              in_data,
  output logic                       in_full,
  output logic                       q_valid,
  output in_word_t                   q_word,
  output logic [31:0]                q_rate,
  output logic [31:0]                q_burst,
  output logic                       q_active,
  input  wire logic                  q_take
);
  logic [31:0] def_rate_r, def_burst_r;
  // Two-entry queue.
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_r, rd_nxt, wr_r, wr_nxt;
  in_word_t    wd_r [2];
  logic [31:0] rt_r [2];
  logic [31:0] bs_r [2];
  logic        ac_r [2];
  logic        push_ok;
  logic        ov_ok, df_ok;

  assign push_ok = in_push && !in_full;
  assign in_full = (cnt_r == 2'd2);
  assign ov_ok   = (in_data.override_rate != '0) && (in_data.override_burst != '0);
  assign df_ok   = (def_rate_r != '0) && (def_burst_r != '0);

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, q_take};
    rd_nxt  = q_take ? !rd_r : rd_r;
    wr_nxt  = push_ok ? !wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_rate_r  <= '0;
      def_burst_r <= '0;
      cnt_r       <= '0;
      rd_r        <= 1'b0;
      wr_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_RATE:  def_rate_r  <= cfg_data;
          CFG_BURST: def_burst_r <= cfg_data;
          default: ;
        endcase
      end
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push_ok) begin
      wd_r[wr_r] <= in_data;
      rt_r[wr_r] <= ov_ok ? in_data.override_rate : def_rate_r;
      bs_r[wr_r] <= ov_ok ? in_data.override_burst : def_burst_r;
      ac_r[wr_r] <= ov_ok || df_ok;
    end
  end

  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = wd_r[rd_r];
  assign q_rate   = rt_r[rd_r];
  assign q_burst  = bs_r[rd_r];
  assign q_active = ac_r[rd_r];

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
    else $error("queue taken while empty");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !q_take) |=> in_full)
    else $error("full queue drained without a take");
endmodule
`default_nettype wire

FILE: design/ftbp_back.sv
// Back end: flow table access, refill arithmetic and the result register.
`default_nettype none
module ftbp_back
  import ftbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire in_word_t    q_word,
  input  wire logic [31:0] q_rate,
  input  wire logic [31:0] q_burst,
  input  wire logic        q_active,
  output logic             q_take,
  output logic             out_empty,
  output out_word_t        out_data,
  input  wire logic        out_pop
);
  localparam int unsigned AW = $clog2(FLOW_SLOTS);
  localparam int unsigned CW = $clog2(FLOW_SLOTS + 1);

  bk_state_t   st_r, st_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic        clearing;
  in_word_t    w_r, w_nxt;
  logic [31:0] rate_r, rate_nxt, burst_r, burst_nxt;
  logic [31:0] tok_r, tok_nxt;
  logic [31:0] qe_r, qe_nxt;
  logic [63:0] dlt_r, dlt_nxt;
  logic [63:0] acc_r, acc_nxt;
  out_word_t   res_r, res_nxt;
  logic        full_r, full_nxt;
  logic        vld_we, vld_wd, tab_we;
  logic [63:0] tab_t_wd;
  logic [31:0] tab_k_wd;
  logic [AW-1:0] tab_addr;
  logic        vld_q;
  logic [63:0] time_q;
  logic [31:0] cnt_q;
  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] tk;

  assign clearing = (clr_r != CW'(FLOW_SLOTS));
  // The table has one slot for every flow index value, so the index needs no reduction.
  assign tab_addr = clearing ? clr_r[AW-1:0] : w_r.flow_index;

  ftbp_ram #(.WIDTH(1), .DEPTH(FLOW_SLOTS)) u_vld (
    .clk(clk), .wr_en(vld_we || clearing), .wr_addr(tab_addr),
    .wr_data(clearing ? 1'b0 : vld_wd), .rd_addr(tab_addr), .rd_data(vld_q));
  ftbp_ram #(.WIDTH(64), .DEPTH(FLOW_SLOTS)) u_time (
    .clk(clk), .wr_en(tab_we), .wr_addr(tab_addr), .wr_data(tab_t_wd),
    .rd_addr(tab_addr), .rd_data(time_q));
  ftbp_ram #(.WIDTH(32), .DEPTH(FLOW_SLOTS)) u_tok (
    .clk(clk), .wr_en(tab_we), .wr_addr(tab_addr), .wr_data(tab_k_wd),
    .rd_addr(tab_addr), .rd_data(cnt_q));

  ftbp_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q));

  // One shared 32x32 multiplier; the state alone selects its operands.
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    mul_a = '0;
    mul_b = NS_PER_SEC[31:0];
    unique case (st_r)
      BK_EVAL: mul_a = burst_r - cnt_q;
      BK_MUL1: begin
        mul_a = dlt_r[31:0];
        mul_b = rate_r;
      end
      BK_MUL2: begin
        mul_a = dlt_r[63:32];
        mul_b = rate_r;
      end
      BK_EST: begin
        mul_a = acc_r[61:30];
        mul_b = RECIP_LO;
      end
      BK_FIX1: mul_a = qe_r;
      default: ;
    endcase
  end

  // On a partial refill the elapsed time is short of the time that fills the
  // bucket, so the product elapsed * rate stays below 2^62 and the gain below
  // 2^32. The gain is estimated from the top 32 bits of the product with a
  // reciprocal of 1e9; the estimate falls short by at most two, and the
  // remainder left after it sets the correction.
  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clearing ? clr_r + CW'(1) : clr_r;
    w_nxt     = w_r;
    rate_nxt  = rate_r;
    burst_nxt = burst_r;
    tok_nxt   = tok_r;
    qe_nxt    = qe_r;
    dlt_nxt   = dlt_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    full_nxt  = full_r && !out_pop;
    q_take    = 1'b0;
    vld_we    = 1'b0;
    vld_wd    = 1'b1;
    tab_we    = 1'b0;
    tab_t_wd  = w_r.now_ns;
    tab_k_wd  = '0;
    div_start = 1'b0;
    div_a     = acc_r;
    div_b     = {32'd0, rate_r};
    tk        = tok_r;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid && !clearing) begin
          q_take    = 1'b1;
          w_nxt     = q_word;
          rate_nxt  = q_rate;
          burst_nxt = q_burst;
          if (!q_active) begin
            res_nxt = '{allow: 1'b1, limiter_active: 1'b0, new_flow: 1'b0, tokens_left: '0};
            st_nxt  = BK_OUT;
          end else begin
            st_nxt = BK_READ;
          end
        end
      end
      BK_READ: st_nxt = BK_EVAL;
      BK_EVAL: begin
        tok_nxt = cnt_q;
        dlt_nxt = w_r.now_ns - time_q;
        if (!vld_q) begin
          vld_we   = 1'b1;
          tab_we   = 1'b1;
          tab_k_wd = burst_r - 32'd1;
          res_nxt  = '{allow: 1'b1, limiter_active: 1'b1, new_flow: 1'b1,
                       tokens_left: burst_r - 32'd1};
          st_nxt   = BK_OUT;
        end else if (cnt_q >= burst_r) begin
          st_nxt = BK_DONE;
        end else begin
          acc_nxt = mul_p;
          st_nxt  = BK_NEED;
        end
      end
      BK_NEED: begin
        div_a     = acc_r + {32'd0, rate_r} - 64'd1;
        div_start = 1'b1;
        st_nxt    = BK_DIV;
      end
      BK_DIV: begin
        if (div_done) begin
          if (dlt_r >= div_q) begin
            tok_nxt = burst_r;
            st_nxt  = BK_DONE;
          end else begin
            st_nxt = BK_MUL1;
          end
        end
      end
      BK_MUL1: begin
        acc_nxt = mul_p;
        st_nxt  = BK_MUL2;
      end
      BK_MUL2: begin
        acc_nxt = acc_r + {mul_p[31:0], 32'd0};
        st_nxt  = BK_EST;
      end
      BK_EST: begin
        qe_nxt = acc_r[61:30] + mul_p[63:32];
        st_nxt = BK_FIX1;
      end
      BK_FIX1: begin
        acc_nxt = acc_r - mul_p;
        st_nxt  = BK_FIX2;
      end
      BK_FIX2: begin
        if (acc_r >= (NS_PER_SEC << 1)) begin
          qe_nxt = qe_r + 32'd2;
        end else if (acc_r >= NS_PER_SEC) begin
          qe_nxt = qe_r + 32'd1;
        end
        st_nxt = BK_CAP;
      end
      BK_CAP: begin
        if (qe_r > burst_r - tok_r) begin
          tok_nxt = burst_r;
        end else begin
          tok_nxt = tok_r + qe_r;
        end
        st_nxt = BK_DONE;
      end
      BK_DONE: begin
        tab_we = 1'b1;
        tk     = tok_r;
        if (tk == '0) begin
          tab_k_wd = '0;
          res_nxt  = '{allow: 1'b0, limiter_active: 1'b1, new_flow: 1'b0, tokens_left: '0};
        end else begin
          tab_k_wd = tk - 32'd1;
          res_nxt  = '{allow: 1'b1, limiter_active: 1'b1, new_flow: 1'b0,
                       tokens_left: tk - 32'd1};
        end
        st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!full_r || out_pop) begin
          full_nxt = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      clr_r  <= '0;
      full_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      full_r <= full_nxt;
    end
    w_r     <= w_nxt;
    rate_r  <= rate_nxt;
    burst_r <= burst_nxt;
    tok_r   <= tok_nxt;
    qe_r    <= qe_nxt;
    dlt_r   <= dlt_nxt;
    acc_r   <= acc_nxt;
    if (st_r == BK_OUT && (!full_r || out_pop)) begin
      out_data <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_empty = !full_r;

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n) q_take |-> !clearing)
    else $error("item taken during table clear");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == BK_DIV))
    else $error("divider finished outside its wait state");
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(full_r)) |-> $past(st_r == BK_OUT))
    else $error("result register loaded outside the output state");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_FIX2) |-> (acc_r < 64'd3000000000))
    else $error("gain estimate off by more than two");
endmodule
`default_nettype wire

FILE: design/per_flow_token_bucket_policer_core.sv
// Top level of the per-flow token bucket policer.
//
//  channel   dir  handshake        payload
//  in_       in   in_push/in_full  in_data   (in_word_t)
//  out_      out  out_pop/out_empty out_data (out_word_t)
//  cfg_      in   cfg_we           cfg_index, cfg_data
//
// An item goes straight from idle to the output state when no limit applies;
// when its slot is new it passes through read and evaluate, and when the bucket
// is already full also through the done state. A refill first runs the
// bit-serial divider for the time that tops up the bucket; when the elapsed time
// covers it the bucket is filled, else the gain is scaled through the shared
// 32x32 multiplier instead. After reset the flow table's valid memory is cleared,
// one slot per cycle, for all FLOW_SLOTS (1024) slots; the front queue takes two
// words meanwhile and then holds off the input.
// A two-word queue lets the front accept while the back computes, and the
// result register lets the back finish while the output is stalled.
`default_nettype none
module per_flow_token_bucket_policer_core
  import ftbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  input  wire in_word_t              in_data,
  output logic                       in_full,
  output logic                       out_empty,
  output out_word_t                  out_data,
  input  wire logic                  out_pop
);
  logic        q_valid, q_active, q_take;
  in_word_t    q_word;
  logic [31:0] q_rate, q_burst;

  // The front resolves override versus default so the back sees a single limit.
  ftbp_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .q_valid(q_valid), .q_word(q_word), .q_rate(q_rate), .q_burst(q_burst),
    .q_active(q_active), .q_take(q_take));

  // The back owns the flow table and the refill arithmetic.
  ftbp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word), .q_rate(q_rate),
    .q_burst(q_burst), .q_active(q_active), .q_take(q_take), .out_empty(out_empty),
    .out_data(out_data), .out_pop(out_pop));
endmodule
`default_nettype wire
